@@ hdl/sem_pkg.sv @@
// Shared types, constants and helper functions for the Sobel edge magnitude block.
package sem_pkg;

    localparam int SEM_MAX_WIDTH  = 1024;
    localparam int SEM_MAX_HEIGHT = 1024;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int PIX_W     = 24;
    localparam int CH_W      = 8;
    localparam int GRAD_W    = 11;
    localparam int SUMSQ_W   = 21;
    localparam int SQ_STAGES = 4;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 11'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 11'd480;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // Above this sum of squares the rounded root is at least 255.
    localparam logic [SUMSQ_W-1:0] MAG_SAT_LIMIT = 21'd65280;
    localparam logic [CH_W-1:0]    MAG_MAX       = 8'd255;

    // Partial result of the digit-by-digit square root.
    typedef struct packed {
        logic [10:0] rem;
        logic [7:0]  root;
    } sqrt_t;

    // Control carried with an item from the line store read to the window update.
    typedef struct packed {
        logic write;
        logic emit;
        logic last;
        logic top;
        logic bottom;
        logic left;
        logic right;
        logic fwd;
    } s1_ctl_t;

    // One radix-4 step: bring in two radicand bits and decide one root bit.
    function automatic sqrt_t sqrt_step(input sqrt_t a, input logic [1:0] d);
        logic [10:0] r;
        logic [10:0] t;
        sqrt_t       res;
        r = {a.rem[8:0], d};
        t = {1'b0, a.root, 2'b01};
        if (r >= t)
        begin
            res.rem  = r - t;
            res.root = {a.root[6:0], 1'b1};
        end
        else
        begin
            res.rem  = r;
            res.root = {a.root[6:0], 1'b0};
        end
        return res;
    endfunction

    // Round the root to nearest using the final remainder, then saturate.
    function automatic logic [CH_W-1:0] mag_round(input sqrt_t a, input logic sat);
        logic [CH_W-1:0] m;
        if (sat)
            m = MAG_MAX;
        else if (a.rem > {3'b000, a.root})
            m = a.root + 8'd1;
        else
            m = a.root;
        return m;
    endfunction

endpackage

@@ hdl/sem_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
module sem_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem_reg[waddr] <= wdata;
        if (re)
            rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ hdl/sobel_edge_magnitude_rgb.sv @@
// Sobel edge magnitude over an RGB raster stream, 3x3 window with two line stores.
// Throughput: one request per cycle unless the output stalls; one read, one write port per store.
// Path: the request that completes a window comes image_width + 1 requests after its pixel; the
// result then passes the s1, gradient, radicand and root stage registers to the output register.
// Reset (rst_n, asynchronous, active low) sets the size to 640x480 and clears the window,
// the frame counters and all pipeline valid flags; the line stores are not cleared.
module sobel_edge_magnitude_rgb
    import sem_pkg::*;
#(
    parameter int MAX_WIDTH  = SEM_MAX_WIDTH,
    parameter int MAX_HEIGHT = SEM_MAX_HEIGHT
) (
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 op,
    input  logic [CH_W-1:0]      pixel_red,
    input  logic [CH_W-1:0]      pixel_green,
    input  logic [CH_W-1:0]      pixel_blue,

    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CH_W-1:0]      edge_red,
    output logic [CH_W-1:0]      edge_green,
    output logic [CH_W-1:0]      edge_blue,
    output logic                 frame_end,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    // Column, row and raster counter widths. The raster counter also has to count the
    // flush requests that follow the last pixel, hence the extra line plus two.
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int NW = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 2);

    // ------------------------------------------------------------------
    // Configuration registers and the sizes actually used.
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] cfg_w_reg;
    logic [CFG_W-1:0] cfg_h_reg;
    logic [NW-1:0]    used_w;
    logic [NW-1:0]    used_h;
    logic [NW-1:0]    total;
    logic             cfg_hit;

    // A zero size is treated as one, anything above the maximum as the maximum.
    always_comb
    begin
        if (cfg_w_reg == '0)
            used_w = NW'(1);
        else if (32'(cfg_w_reg) > 32'(MAX_WIDTH))
            used_w = NW'(MAX_WIDTH);
        else
            used_w = NW'(cfg_w_reg);

        if (cfg_h_reg == '0)
            used_h = NW'(1);
        else if (32'(cfg_h_reg) > 32'(MAX_HEIGHT))
            used_h = NW'(MAX_HEIGHT);
        else
            used_h = NW'(cfg_h_reg);
    end

    assign total     = NW'(used_w * used_h);
    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid && cfg_ready &&
                       (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

    // ------------------------------------------------------------------
    // Input side: frame position of the next request and of the next result.
    // ------------------------------------------------------------------
    logic [CW-1:0] in_col_reg;
    logic [NW-1:0] in_count_reg;
    logic [CW-1:0] out_col_reg;
    logic [RW-1:0] out_row_reg;
    logic [NW-1:0] out_count_reg;
    logic          out_valid_reg;

    logic adv;
    logic in_acc;
    logic draining;
    logic enter;
    logic emit;
    logic last;
    logic col_wrap;
    logic ocol_wrap;

    // The whole pipeline moves together whenever the output register can take a new result.
    assign adv       = !out_valid_reg || out_ready;
    assign in_ready  = adv;
    assign in_acc    = in_valid && adv;

    // Once every pixel of the frame has arrived, each request (flush or pixel) only drains.
    // A flush that comes earlier is accepted and dropped without touching any state.
    assign draining  = in_count_reg >= total;
    assign enter     = in_acc && !(op == OP_FLUSH && !draining);
    assign emit      = in_count_reg >= (used_w + NW'(1));
    assign last      = (out_count_reg + NW'(1)) >= total;
    assign col_wrap  = (NW'(in_col_reg) + NW'(1)) >= used_w;
    assign ocol_wrap = (NW'(out_col_reg) + NW'(1)) >= used_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_w_reg     <= WIDTH_RESET;
            cfg_h_reg     <= HEIGHT_RESET;
            in_col_reg    <= '0;
            in_count_reg  <= '0;
            out_col_reg   <= '0;
            out_row_reg   <= '0;
            out_count_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  cfg_w_reg <= cfg_data;
                REG_IMAGE_HEIGHT: cfg_h_reg <= cfg_data;
                default:          ;
            endcase
            // Any write to a real register starts a new frame.
            if (cfg_hit)
            begin
                in_col_reg    <= '0;
                in_count_reg  <= '0;
                out_col_reg   <= '0;
                out_row_reg   <= '0;
                out_count_reg <= '0;
            end
        end
        else if (enter)
        begin
            if (emit && last)
            begin
                // The last result of the frame goes out with this request.
                in_col_reg    <= '0;
                in_count_reg  <= '0;
                out_col_reg   <= '0;
                out_row_reg   <= '0;
                out_count_reg <= '0;
            end
            else
            begin
                in_col_reg   <= col_wrap ? '0 : in_col_reg + CW'(1);
                in_count_reg <= in_count_reg + NW'(1);
                if (emit)
                begin
                    out_count_reg <= out_count_reg + NW'(1);
                    out_col_reg   <= ocol_wrap ? '0 : out_col_reg + CW'(1);
                    if (ocol_wrap)
                        out_row_reg <= out_row_reg + RW'(1);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Line stores. Each request reads both stores at its column; as it moves from the s1
    // registers into the window, it writes the middle line back into the upper line
    // and the new pixel into the middle line. Draining requests read but do not write.
    // ------------------------------------------------------------------
    logic             s1_valid_reg;
    logic [CW-1:0]    s1_addr_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    s1_ctl_t          s1_ctl_reg;
    logic [PIX_W-1:0] fwd_up_reg;
    logic [PIX_W-1:0] fwd_mid_reg;

    logic [PIX_W-1:0] up_rdata;
    logic [PIX_W-1:0] mid_rdata;
    logic [PIX_W-1:0] s1_up_rd;
    logic [PIX_W-1:0] s1_mid_rd;
    logic             line_we;
    s1_ctl_t          s1_ctl_next;

    assign line_we = adv && s1_valid_reg && s1_ctl_reg.write;

    sem_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper_line (
        .clk   (clk),
        .we    (line_we),
        .waddr (s1_addr_reg),
        .wdata (s1_mid_rd),
        .re    (enter),
        .raddr (in_col_reg),
        .rdata (up_rdata)
    );

    sem_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle_line (
        .clk   (clk),
        .we    (line_we),
        .waddr (s1_addr_reg),
        .wdata (s1_pix_reg),
        .re    (enter),
        .raddr (in_col_reg),
        .rdata (mid_rdata)
    );

    // When the image is one pixel wide, a read and the write of the previous request hit
    // the same entry at the same edge. The RAM returns the old contents then, so the
    // written values are captured and used in place of the read data.
    assign s1_up_rd  = s1_ctl_reg.fwd ? fwd_up_reg  : up_rdata;
    assign s1_mid_rd = s1_ctl_reg.fwd ? fwd_mid_reg : mid_rdata;

    // Border masks describe the neighbourhood of the result this request will produce.
    always_comb
    begin
        s1_ctl_next.write  = !draining;
        s1_ctl_next.emit   = emit;
        s1_ctl_next.last   = emit && last;
        s1_ctl_next.top    = out_row_reg != '0;
        s1_ctl_next.bottom = (NW'(out_row_reg) + NW'(1)) < used_h;
        s1_ctl_next.left   = out_col_reg != '0;
        s1_ctl_next.right  = !ocol_wrap;
        s1_ctl_next.fwd    = s1_valid_reg && s1_ctl_reg.write && (s1_addr_reg == in_col_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= enter;
    end

    always_ff @(posedge clk)
    begin
        if (enter)
        begin
            s1_addr_reg <= in_col_reg;
            s1_pix_reg  <= draining ? '0 : {pixel_red, pixel_green, pixel_blue};
            s1_ctl_reg  <= s1_ctl_next;
            fwd_up_reg  <= s1_mid_rd;
            fwd_mid_reg <= s1_pix_reg;
        end
    end

    // ------------------------------------------------------------------
    // 3x3 window and the Sobel sums. Entry row*3+col, row 0 on top, col 0 on the left.
    // ------------------------------------------------------------------
    logic [PIX_W-1:0]         win_reg [9];
    logic [PIX_W-1:0]         win_new [9];
    logic signed [GRAD_W-1:0] pv      [9];
    logic signed [GRAD_W-1:0] gx_c    [3];
    logic signed [GRAD_W-1:0] gy_c    [3];
    logic [2:0]               row_ok;
    logic [2:0]               col_ok;

    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            win_new[r * 3]     = win_reg[r * 3 + 1];
            win_new[r * 3 + 1] = win_reg[r * 3 + 2];
        end
        win_new[2] = s1_up_rd;
        win_new[5] = s1_mid_rd;
        win_new[8] = s1_pix_reg;

        // Neighbours outside the image count as zero.
        row_ok = {s1_ctl_reg.bottom, 1'b1, s1_ctl_reg.top};
        col_ok = {s1_ctl_reg.right, 1'b1, s1_ctl_reg.left};

        for (int ch = 0; ch < 3; ch++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    pv[r * 3 + c] = (row_ok[r] && col_ok[c]) ?
                        $signed({3'b000, win_new[r * 3 + c][23 - 8 * ch -: 8]}) : '0;
                end
            end
            gx_c[ch] = (pv[2] + (pv[5] <<< 1) + pv[8]) - (pv[0] + (pv[3] <<< 1) + pv[6]);
            gy_c[ch] = (pv[6] + (pv[7] <<< 1) + pv[8]) - (pv[0] + (pv[1] <<< 1) + pv[2]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else if (cfg_hit || (adv && s1_valid_reg && s1_ctl_reg.last))
        begin
            // A new frame starts from an empty window.
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
        end
        else if (adv && s1_valid_reg)
        begin
            for (int i = 0; i < 9; i++)
                win_reg[i] <= win_new[i];
        end
    end

    // ------------------------------------------------------------------
    // Gradient register, then squares and the root pipeline.
    // ------------------------------------------------------------------
    logic                     s2_valid_reg;
    logic                     s2_end_reg;
    logic signed [GRAD_W-1:0] s2_gx_reg [3];
    logic signed [GRAD_W-1:0] s2_gy_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (adv)
            s2_valid_reg <= s1_valid_reg && s1_ctl_reg.emit;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_end_reg <= s1_ctl_reg.last;
            for (int ch = 0; ch < 3; ch++)
            begin
                s2_gx_reg[ch] <= gx_c[ch];
                s2_gy_reg[ch] <= gy_c[ch];
            end
        end
    end

    logic signed [2*GRAD_W-1:0] gx2    [3];
    logic signed [2*GRAD_W-1:0] gy2    [3];
    logic [SUMSQ_W-1:0]         sumsq  [3];

    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            gx2[ch]   = s2_gx_reg[ch] * s2_gx_reg[ch];
            gy2[ch]   = s2_gy_reg[ch] * s2_gy_reg[ch];
            sumsq[ch] = SUMSQ_W'(gx2[ch]) + SUMSQ_W'(gy2[ch]);
        end
    end

    // Stage 0 holds the radicand; each later stage settles two root bits.
    logic        sq_valid_reg [SQ_STAGES+1];
    logic        sq_end_reg   [SQ_STAGES+1];
    sqrt_t       sq_st_reg    [SQ_STAGES+1][3];
    logic [15:0] sq_rad_reg   [SQ_STAGES+1][3];
    logic        sq_sat_reg   [SQ_STAGES+1][3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= SQ_STAGES; k++)
                sq_valid_reg[k] <= 1'b0;
        end
        else if (adv)
        begin
            sq_valid_reg[0] <= s2_valid_reg;
            for (int k = 1; k <= SQ_STAGES; k++)
                sq_valid_reg[k] <= sq_valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sq_end_reg[0] <= s2_end_reg;
            for (int ch = 0; ch < 3; ch++)
            begin
                sq_rad_reg[0][ch] <= sumsq[ch][15:0];
                sq_sat_reg[0][ch] <= sumsq[ch] > MAG_SAT_LIMIT;
                sq_st_reg[0][ch]  <= '0;
            end
            for (int k = 1; k <= SQ_STAGES; k++)
            begin
                sq_end_reg[k] <= sq_end_reg[k-1];
                for (int ch = 0; ch < 3; ch++)
                begin
                    sq_rad_reg[k][ch] <= sq_rad_reg[k-1][ch];
                    sq_sat_reg[k][ch] <= sq_sat_reg[k-1][ch];
                    sq_st_reg[k][ch]  <= sqrt_step(
                        sqrt_step(sq_st_reg[k-1][ch], sq_rad_reg[k-1][ch][19 - 4 * k -: 2]),
                        sq_rad_reg[k-1][ch][17 - 4 * k -: 2]);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register: rounding and saturation, held until the result is taken.
    // ------------------------------------------------------------------
    logic [CH_W-1:0] edge_reg [3];
    logic            frame_end_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= sq_valid_reg[SQ_STAGES];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            frame_end_reg <= sq_end_reg[SQ_STAGES];
            for (int ch = 0; ch < 3; ch++)
                edge_reg[ch] <= mag_round(sq_st_reg[SQ_STAGES][ch], sq_sat_reg[SQ_STAGES][ch]);
        end
    end

    assign out_valid  = out_valid_reg;
    assign edge_red   = edge_reg[0];
    assign edge_green = edge_reg[1];
    assign edge_blue  = edge_reg[2];
    assign frame_end  = frame_end_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------

    // The request that carries the last result of a frame returns both counters to zero.
    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (enter && emit && last && !cfg_valid) |=> (in_count_reg == '0 && out_count_reg == '0))
        else $error("frame counters not cleared after the last result");

    // The result index never reaches the frame size; the restart happens first.
    a_out_index: assert property (@(posedge clk) disable iff (!rst_n)
        out_count_reg < total)
        else $error("result index ran past the end of the frame");

    // Forwarded line data is only used for a request that follows a write to its column.
    a_forward: assert property (@(posedge clk) disable iff (!rst_n)
        (enter && s1_ctl_next.fwd) |-> line_we)
        else $error("line store forwarding without a matching write");

endmodule
